FILE: hdl/wpmt_pkg.sv
package wpmt_pkg;

  // Field widths
  localparam int IDX_W     = 6;
  localparam int IDX_LIMIT = 2 ** IDX_W;
  localparam int DIST_W    = 24;
  localparam int WEIGHT_W  = 16;
  localparam int SUM_W     = 48;
  localparam int WSUM_W    = 32;
  localparam int MEAN_W    = 24;

  // Derived datapath widths
  localparam int PROD_W = DIST_W + WEIGHT_W;   // distance * weight
  localparam int NUM_W  = SUM_W + 1;           // sum plus half the weight
  localparam int DIV_W  = WSUM_W + MEAN_W - 1; // divisor aligned to top quotient bit
  localparam int CNT_W  = $clog2(MEAN_W);

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [IDX_W-1:0]    row_index;
    logic [IDX_W-1:0]    col_index;
    logic [DIST_W-1:0]   distance;
    logic [WEIGHT_W-1:0] weight;
  } req_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_distance;
    logic [WSUM_W-1:0] total_weight;
    logic              no_data;
  } rsp_t;

endpackage

FILE: hdl/wpmt_ram.sv
module wpmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/weighted_pair_mean_table.sv
// Lower-triangular table of pair cells, each holding a Q32.16 weighted distance sum and a
// 32-bit weight sum in one on-chip RAM (read-modify-write through a single read and a single
// write port). After reset the block clears all MAX_ENTRIES*(MAX_ENTRIES-1)/2 cells (2016
// at the default; MAX_ENTRIES is capped at 64 and indices above 63 never address a cell)
// with busy high; the weighted_mode register may still be written then. A request is
// taken when start is high and busy is low. An accumulate request reads its cell from RAM,
// then adds, saturates and writes back. A read request returns its result from S_LOAD when
// the pair holds no data, from S_PREP when the mean saturates, and otherwise after the
// 24-step restoring divider that forms the rounded mean. The result is shown for one cycle
// with done high and cannot be stalled; a new request may be taken in that same cycle.
module weighted_pair_mean_table #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  wpmt_pkg::req_t request,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  output logic           done,
  output wpmt_pkg::rsp_t result
);
  import wpmt_pkg::*;

  localparam int EntryCount = (MAX_ENTRIES > IDX_LIMIT) ? IDX_LIMIT : MAX_ENTRIES;
  localparam int CellCount  = EntryCount * (EntryCount - 1) / 2;
  localparam int AW         = (CellCount > 1) ? $clog2(CellCount) : 1;
  localparam int CW         = IDX_W + 1;
  localparam int RAM_W      = SUM_W + WSUM_W;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_LOAD = 5'b00100,
    S_PREP = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  state_t state;

  logic weighted_mode;

  // Request capture
  logic                accept;
  logic [IDX_W-1:0]    hi_idx;
  logic [IDX_W-1:0]    lo_idx;
  logic                pair_ok;
  logic [2*IDX_W-1:0]  tri_prod;
  logic [2*IDX_W-1:0]  pos;
  logic [AW-1:0]       cell_addr;
  logic [WEIGHT_W-1:0] w_eff;
  logic [PROD_W-1:0]   prod_c;

  logic                item_kind;
  logic                item_ok;
  logic [AW-1:0]       item_addr;
  logic [PROD_W-1:0]   item_prod;
  logic [WEIGHT_W-1:0] item_w;

  // Memory
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;
  logic [AW-1:0]     clr_cnt;

  logic [SUM_W-1:0]  rd_sum;
  logic [WSUM_W-1:0] rd_w;
  logic [SUM_W:0]    acc_sum;
  logic [WSUM_W:0]   acc_w;
  logic [SUM_W-1:0]  sum_new;
  logic [WSUM_W-1:0] w_new;

  // Divider
  logic [NUM_W-1:0]  div_r;
  logic [WSUM_W-1:0] den;
  logic [DIV_W-1:0]  div_d;
  logic [MEAN_W-1:0] div_q;
  logic [CNT_W-1:0]  div_cnt;
  logic              div_ge;
  logic              mean_sat;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    hi_idx   = (request.row_index > request.col_index) ? request.row_index : request.col_index;
    lo_idx   = (request.row_index > request.col_index) ? request.col_index : request.row_index;
    pair_ok  = (request.row_index != request.col_index)
               && (CW'(request.row_index) < CW'(EntryCount))
               && (CW'(request.col_index) < CW'(EntryCount));
    tri_prod = {{IDX_W{1'b0}}, hi_idx} * {{IDX_W{1'b0}}, hi_idx - 1'b1};
    pos      = (tri_prod >> 1) + {{IDX_W{1'b0}}, lo_idx};
    cell_addr = pair_ok ? pos[AW-1:0] : '0;
    w_eff    = weighted_mode ? request.weight : WEIGHT_W'(1);
    prod_c   = request.distance * w_eff;
  end

  always_comb begin
    rd_sum  = ram_rdata[RAM_W-1:WSUM_W];
    rd_w    = ram_rdata[WSUM_W-1:0];
    acc_sum = {1'b0, rd_sum} + (SUM_W + 1)'(item_prod);
    acc_w   = {1'b0, rd_w} + (WSUM_W + 1)'(item_w);
    sum_new = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
    w_new   = acc_w[WSUM_W] ? WSUM_MAX : acc_w[WSUM_W-1:0];
  end

  always_comb begin
    ram_we    = (state == S_CLR) || ((state == S_LOAD) && (item_kind == KIND_ACC) && item_ok);
    ram_waddr = (state == S_CLR) ? clr_cnt : item_addr;
    ram_wdata = (state == S_CLR) ? '0 : {sum_new, w_new};
  end

  // Quotient below 2^24 exactly when num < den * 2^24
  assign mean_sat = ((DIV_W + 1)'(div_r) >= {den, {MEAN_W{1'b0}}});
  assign div_ge   = (DIV_W'(div_r) >= div_d);

  wpmt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CellCount)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_cnt       <= '0;
      weighted_mode <= 1'b1;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        weighted_mode <= cfg_data;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(CellCount - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (item_kind == KIND_ACC) begin
            state <= S_IDLE;
          end else if (!item_ok || rd_w == '0) begin
            done                 <= 1'b1;
            result.mean_distance <= '0;
            result.total_weight  <= '0;
            result.no_data       <= 1'b1;
            state                <= S_IDLE;
          end else begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (mean_sat) begin
            done                 <= 1'b1;
            result.mean_distance <= MEAN_MAX;
            result.total_weight  <= den;
            result.no_data       <= 1'b0;
            state                <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            done                 <= 1'b1;
            result.mean_distance <= {div_q[MEAN_W-2:0], div_ge};
            result.total_weight  <= den;
            result.no_data       <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= request.kind;
      item_ok   <= pair_ok;
      item_addr <= cell_addr;
      item_prod <= prod_c;
      item_w    <= w_eff;
    end
    case (state)
      S_LOAD: begin
        // rounding: add half the weight before dividing
        div_r <= {1'b0, rd_sum} + NUM_W'(rd_w >> 1);
        den   <= rd_w;
      end
      S_PREP: begin
        div_d   <= {den, {(MEAN_W - 1){1'b0}}};
        div_q   <= '0;
        div_cnt <= CNT_W'(MEAN_W - 1);
      end
      S_DIV: begin
        if (div_ge) begin
          div_r <= div_r - div_d[NUM_W-1:0];
        end
        div_q   <= {div_q[MEAN_W-2:0], div_ge};
        div_d   <= div_d >> 1;
        div_cnt <= div_cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy next cycle");

  a_nodata_mean: assert property (@(posedge clk) disable iff (rst)
    done && result.no_data |-> result.mean_distance == '0)
    else $error("no-data result with non-zero mean");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !ram_we)
    else $error("cell memory written while idle");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_LOAD || state == S_PREP || state == S_DIV))
    else $error("result strobe without a read in progress");

endmodule
